FILE: rtl/qeg_pkg.sv
// ----------------------------------------------------------------------------
// qeg_pkg
// Shared constants for the quantizing exp-Golomb symbol coder.
// ----------------------------------------------------------------------------
`default_nettype none
package qeg_pkg;
   localparam int unsigned QUANT_WIDTH = 11;
   localparam logic [QUANT_WIDTH-1:0] QUANT_RESET = 11'd1024;
   localparam logic [1:0] SYM_BITS_ONE = 2'd1;
   localparam logic [1:0] SYM_BITS_TWO = 2'd2;
endpackage
`default_nettype wire

FILE: rtl/qeg_divider.sv
// ----------------------------------------------------------------------------
// qeg_divider
// Pipelined restoring divider: magnitude by quantizer, one quotient bit per
// stage, with valid bits and a common stall.
// ----------------------------------------------------------------------------
`default_nettype none
module qeg_divider #(
   parameter int unsigned MAG_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [MAG_WIDTH-1:0]          in_mag,
   input  wire logic [qeg_pkg::QUANT_WIDTH-1:0] in_quant,
   input  wire logic                          in_neg,
   input  wire logic                          in_eob,
   output logic                               out_valid,
   output logic [MAG_WIDTH-1:0]               out_quot,
   output logic                               out_neg,
   output logic                               out_eob
);
   import qeg_pkg::*;

   localparam int unsigned RW = QUANT_WIDTH + 1;

   // Register stage s holds a transaction after s quotient bits are known.
   logic                   valid_ff [1:MAG_WIDTH];
   logic [MAG_WIDTH-1:0]   num_ff   [1:MAG_WIDTH];
   logic [QUANT_WIDTH-1:0] rem_ff   [1:MAG_WIDTH];
   logic [QUANT_WIDTH-1:0] quant_ff [1:MAG_WIDTH];
   logic                   neg_ff   [1:MAG_WIDTH];
   logic                   eob_ff   [1:MAG_WIDTH];

   // Each stage shifts one numerator bit into the remainder and subtracts.
   for (genvar s = 0; s < MAG_WIDTH; s++) begin : g_stage
      logic                   cur_valid, cur_neg, cur_eob;
      logic [MAG_WIDTH-1:0]   cur_num;
      logic [QUANT_WIDTH-1:0] cur_rem, cur_quant;
      logic [RW-1:0]          trial;
      logic [RW:0]            diff;
      logic [MAG_WIDTH-1:0]   num_in;
      logic [QUANT_WIDTH-1:0] rem_in;

      if (s == 0) begin : g_head
         assign cur_valid = in_valid;
         assign cur_num   = in_mag;
         assign cur_rem   = '0;
         assign cur_quant = in_quant;
         assign cur_neg   = in_neg;
         assign cur_eob   = in_eob;
      end else begin : g_body
         assign cur_valid = valid_ff[s];
         assign cur_num   = num_ff[s];
         assign cur_rem   = rem_ff[s];
         assign cur_quant = quant_ff[s];
         assign cur_neg   = neg_ff[s];
         assign cur_eob   = eob_ff[s];
      end

      always_comb begin
         trial  = {cur_rem, cur_num[MAG_WIDTH-1]};
         diff   = {1'b0, trial} - {2'b00, cur_quant};
         num_in = {cur_num[MAG_WIDTH-2:0], ~diff[RW]};
         rem_in = diff[RW] ? trial[QUANT_WIDTH-1:0] : diff[QUANT_WIDTH-1:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= cur_valid;
         end
         if (advance) begin
            num_ff[s+1]   <= num_in;
            rem_ff[s+1]   <= rem_in;
            quant_ff[s+1] <= cur_quant;
            neg_ff[s+1]   <= cur_neg;
            eob_ff[s+1]   <= cur_eob;
         end
      end
   end

   assign out_valid = valid_ff[MAG_WIDTH];
   assign out_quot  = num_ff[MAG_WIDTH];
   assign out_neg   = neg_ff[MAG_WIDTH];
   assign out_eob   = eob_ff[MAG_WIDTH];
endmodule
`default_nettype wire

FILE: rtl/quantize_exp_golomb_symbols.sv
// ----------------------------------------------------------------------------
// quantize_exp_golomb_symbols
// Quantizes coefficients and emits interleaved order-0 exp-Golomb symbols.
// ----------------------------------------------------------------------------
// A coefficient enters on every cycle in which the divider pipeline can move;
// it is registered, passes the divider stages, the serializer state and the
// output register, and then its first symbol appears. Symbols are serialized
// at one per cycle while the receiver is ready: one for a zero quotient,
// otherwise 2 + floor(log2(|q|+1)); the serializer, which sets the sustained
// rate, takes the next quotient as it emits its final symbol. The quantizer is
// captured with each coefficient, so it may be written at any idle time.
`default_nettype none
module quantize_exp_golomb_symbols #(
   parameter int unsigned COEF_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coefficient,
   input  wire logic                          req_end_of_block,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [qeg_pkg::QUANT_WIDTH-1:0] csr_quantizer,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_symbol_value,
   output logic [1:0]                         rsp_symbol_bits,
   output logic                               rsp_last_of_coefficient,
   output logic                               rsp_block_done
);
   import qeg_pkg::*;

   localparam int unsigned IW = $clog2(COEF_WIDTH + 1);

   logic [QUANT_WIDTH-1:0] quant_ff;
   logic                   advance;
   logic                   in_valid_ff, in_neg_ff, in_eob_ff;
   logic [COEF_WIDTH-1:0]  in_mag_ff;
   logic [QUANT_WIDTH-1:0] in_quant_ff;
   logic                   dv, dneg, deob;
   logic [COEF_WIDTH-1:0]  dquot;

   // Serializer state: v = q+1 held with a bit pointer.
   logic                   busy_ff;
   logic [COEF_WIDTH:0]    v_ff;
   logic [IW-1:0]          idx_ff;
   logic                   phase_ff;    // 0 data bits, 1 terminator, then sign
   logic                   zero_ff, neg_ff, eob_ff, term_done_ff;
   logic                   ser_take, ser_free;

   logic                   out_valid_ff;
   logic [1:0]             out_value_ff, out_bits_ff;
   logic                   out_last_ff, out_done_ff;
   logic                   out_free;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_ff <= QUANT_RESET;
      end else if (csr_valid) begin
         quant_ff <= csr_quantizer;
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   // The serializer is free when idle or emitting its final symbol.
   logic ser_last;
   assign ser_last = busy_ff && (zero_ff || term_done_ff);
   assign ser_free = !busy_ff || (ser_last && out_free);
   assign advance   = !dv || ser_free;
   assign ser_take  = dv && ser_free;
   assign req_ready = advance;

   logic [COEF_WIDTH-1:0] mag_in;
   assign mag_in = req_coefficient[COEF_WIDTH-1] ? (~req_coefficient + 1'b1)
                                                 : req_coefficient;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_mag_ff   <= mag_in;
         in_neg_ff   <= req_coefficient[COEF_WIDTH-1];
         in_eob_ff   <= req_end_of_block;
         in_quant_ff <= (quant_ff == '0) ? QUANT_WIDTH'(1) : quant_ff;
      end
   end

   qeg_divider #(.MAG_WIDTH(COEF_WIDTH)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(in_valid_ff), .in_mag(in_mag_ff), .in_quant(in_quant_ff),
      .in_neg(in_neg_ff), .in_eob(in_eob_ff),
      .out_valid(dv), .out_quot(dquot), .out_neg(dneg), .out_eob(deob)
   );

   // Leading-one position of q+1 with a priority loop over independent bits.
   logic [COEF_WIDTH:0] v_new;
   logic [IW-1:0]       top;
   always_comb begin
      v_new = {1'b0, dquot} + 1'b1;
      top = '0;
      for (int b = 1; b <= COEF_WIDTH; b++) begin
         if (v_new[b]) top = IW'(b);
      end
   end

   logic [1:0] sym_value, sym_bits;
   logic       sym_last, sym_done;
   always_comb begin
      sym_value = 2'd1;
      sym_bits  = SYM_BITS_ONE;
      sym_last  = 1'b0;
      sym_done  = 1'b0;
      if (zero_ff) begin
         sym_last = 1'b1;
         sym_done = eob_ff;
      end else if (term_done_ff) begin
         sym_value = {1'b0, neg_ff};
         sym_last  = 1'b1;
         sym_done  = eob_ff;
      end else if (!phase_ff) begin
         sym_value = {v_ff[idx_ff - 1'b1], 1'b0};
         sym_bits  = SYM_BITS_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ser_take) begin
         busy_ff <= 1'b1;
      end else if (ser_last && out_free) begin
         busy_ff <= 1'b0;
      end
      if (ser_take) begin
         v_ff         <= v_new;
         idx_ff       <= top;
         phase_ff     <= (top == '0);
         zero_ff      <= (dquot == '0);
         neg_ff       <= dneg;
         eob_ff       <= deob;
         term_done_ff <= 1'b0;
      end else if (busy_ff && out_free) begin
         if (!phase_ff) begin
            idx_ff <= idx_ff - 1'b1;
            if (idx_ff == IW'(1)) phase_ff <= 1'b1;
         end else begin
            term_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= busy_ff;
      end
      if (out_free) begin
         out_value_ff <= sym_value;
         out_bits_ff  <= sym_bits;
         out_last_ff  <= sym_last;
         out_done_ff  <= sym_done;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_symbol_value        = out_value_ff;
   assign rsp_symbol_bits         = out_bits_ff;
   assign rsp_last_of_coefficient = out_last_ff;
   assign rsp_block_done          = out_done_ff;
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives coefficients through the quantizing exp-Golomb coder under random
// idling, predicts every symbol in a scoreboard and checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class symbol_scoreboard;
   typedef struct packed {
      logic [1:0] value;
      logic [1:0] bits;
      logic       last;
      logic       done;
   } symbol_type;

   symbol_type pending[$];
   int      errors;
   logic [qeg_pkg::QUANT_WIDTH-1:0] quantizer;

   function new();
      errors = 0;
      quantizer = qeg_pkg::QUANT_RESET;
   endfunction

   // Expands one accepted coefficient into its expected symbols.
   function void note_coefficient(logic signed [23:0] coef, logic eob);
      logic [63:0] mag;
      logic [63:0] qmag;
      logic [63:0] v;
      logic [63:0] qp;
      symbol_type s;
      int top;
      mag = coef[23] ? 64'(-$signed({{40{coef[23]}}, coef})) : 64'(coef);
      qp = (quantizer == 0) ? 64'd1 : 64'(quantizer);
      qmag = mag / qp;
      if (qmag == 0) begin
         s = '{2'd1, qeg_pkg::SYM_BITS_ONE, 1'b1, eob};
         pending.push_back(s);
         return;
      end
      v = qmag + 1;
      top = 0;
      while (top < 63 && (v >> (top + 1)) != 0) top++;
      for (int i = top - 1; i >= 0; i--) begin
         s = '{{v[i], 1'b0}, qeg_pkg::SYM_BITS_TWO, 1'b0, 1'b0};
         pending.push_back(s);
      end
      s = '{2'd1, qeg_pkg::SYM_BITS_ONE, 1'b0, 1'b0};
      pending.push_back(s);
      s = '{{1'b0, coef[23]}, qeg_pkg::SYM_BITS_ONE, 1'b1, eob};
      pending.push_back(s);
   endfunction

   task check_symbol(symbol_type got);
      symbol_type want;
      if (pending.size() == 0) begin
         report_mismatch("symbol with nothing expected", got, got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) report_mismatch("symbol mismatch", got, want);
   endtask

   task report_mismatch(string what, symbol_type got, symbol_type want);
      $display("ERROR %0t: %s: got v=%0d b=%0d l=%0d d=%0d, want v=%0d b=%0d l=%0d d=%0d",
               $time, what, got.value, got.bits, got.last, got.done,
               want.value, want.bits, want.last, want.done);
      errors++;
   endtask
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [23:0] req_coefficient = 0;
   logic req_end_of_block = 0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [qeg_pkg::QUANT_WIDTH-1:0] csr_quantizer = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_symbol_value;
   logic [1:0] rsp_symbol_bits;
   logic rsp_last_of_coefficient;
   logic rsp_block_done;

   symbol_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always #2 clock = ~clock;

   quantize_exp_golomb_symbols #(.COEF_WIDTH(24)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_coefficient(req_coefficient), .req_end_of_block(req_end_of_block),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_quantizer(csr_quantizer),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_symbol_value(rsp_symbol_value), .rsp_symbol_bits(rsp_symbol_bits),
      .rsp_last_of_coefficient(rsp_last_of_coefficient),
      .rsp_block_done(rsp_block_done)
   );

   // Receiver: sample at the rising edge, change ready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_symbol({rsp_symbol_value, rsp_symbol_bits,
                             rsp_last_of_coefficient, rsp_block_done});
   end
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Valid stays high after an accepted transaction only when the next one
   // follows at once; idling and the other tasks drop it.
   task automatic send_coefficient(logic signed [23:0] coef, logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_coefficient <= coef;
      req_end_of_block <= eob;
      do @(posedge clock); while (!req_ready);
      board.note_coefficient(coef, eob);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_quantizer(logic [qeg_pkg::QUANT_WIDTH-1:0] q);
      drain();
      csr_valid <= 1;
      csr_quantizer <= q;
      do @(posedge clock); while (!csr_ready);
      board.quantizer = q;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Mostly small coefficients relative to the quantizer, a few full-range.
   function automatic logic signed [23:0] random_coefficient();
      int span;
      case ($urandom_range(9))
         0, 1: return 24'($urandom);
         2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
         default: begin
            span = (board.quantizer == 0 ? 1 : board.quantizer) * 40;
            return 24'($signed($urandom_range(2 * span)) - span);
         end
      endcase
   endfunction

   initial begin
      logic [qeg_pkg::QUANT_WIDTH-1:0] qlist[5];
      qlist = '{11'd1, 11'd2047, 11'd0, 11'd7, 11'd300};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: reset quantizer, then extremes at quantizers 1, 0 and 2047.
      send_coefficient(24'sd0, 1'b0);
      send_coefficient(24'sd1023, 1'b0);
      send_coefficient(24'sd1024, 1'b1);
      send_coefficient(-24'sd1024, 1'b0);
      send_coefficient(24'sh7FFFFF, 1'b1);
      write_quantizer(11'd1);
      send_coefficient(24'sh800000, 1'b1);
      send_coefficient(24'sh7FFFFF, 1'b0);
      send_coefficient(24'sd1, 1'b0);
      send_coefficient(-24'sd1, 1'b1);
      send_coefficient(24'sd0, 1'b1);
      send_coefficient(24'sd2, 1'b0);
      send_coefficient(-24'sd6, 1'b0);
      write_quantizer(11'd0);
      send_coefficient(-24'sd5, 1'b1);
      send_coefficient(24'sh800000, 1'b0);
      write_quantizer(11'd2047);
      send_coefficient(24'sd2046, 1'b0);
      send_coefficient(-24'sd2047, 1'b1);
      send_coefficient(24'sh800000, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 33 : 0;
         for (int k = 0; k < 50; k++) begin
            if (k % 10 == 0) write_quantizer(qlist[$urandom_range(4)]);
            if (k == 25) drain();
            send_coefficient(random_coefficient(), ($urandom_range(3) == 0));
         end
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("** quantize_exp_golomb_symbols: PASSED **");
      else
         $display("** quantize_exp_golomb_symbols: FAILED **");
      $finish;
   end

   initial begin
      #2000000;
      $display("** quantize_exp_golomb_symbols: FAILED **");
      $finish;
   end
endmodule

FILE: sim.f
rtl/qeg_pkg.sv
rtl/qeg_divider.sv
rtl/quantize_exp_golomb_symbols.sv
tb/testbench.sv
